FILE: sv/ndrd_pkg.sv
// shared types and codes for the data run decoder
package ndrd_pkg;

  localparam int CountW = 48;
  localparam int LcnW   = 64;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_OFFSET = 4'b0100,
    PH_ENDED  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic              run_valid;
    logic [CountW-1:0] run_clusters;
    logic [LcnW-1:0]   run_start_cluster;
    logic              run_sparse;
    logic              list_end;
  } result_t;

endpackage

FILE: sv/ntfs_data_run_decoder.sv
// Decodes a non-resident data run list one byte per cycle, while in_stall is low,
// into absolute runs. Each header, length byte and offset byte is decoded as it is
// taken, and the byte that completes a run produces its result in the same pass,
// registered into a two-entry output buffer. in_stall goes high while both buffer
// entries hold results not yet taken, or while a configuration request is offered,
// so with a consuming side that keeps up and no configuration request the rate is
// exactly one byte per cycle. Writes of the cluster total on cfg_total are always
// taken (cfg_ready stays high) and should come while the decoder is idle; the
// remaining cluster count is tracked in a register of its own so that the clamp
// and the end test need only a compare and a subtract.
module ntfs_data_run_decoder (
  input  logic                       clk,
  input  logic                       rst,
  // run list bytes
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 run_byte,
  input  logic                       list_start,
  // decoded runs
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       run_valid,
  output logic [ndrd_pkg::CountW-1:0] run_clusters,
  output logic [ndrd_pkg::LcnW-1:0]  run_start_cluster,
  output logic                       run_sparse,
  output logic                       list_end,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ndrd_pkg::CountW-1:0] cfg_total
);

  localparam int CountW = ndrd_pkg::CountW;
  localparam int LcnW   = ndrd_pkg::LcnW;

  // decode state
  ndrd_pkg::phase_t    phase, phase_next;
  logic [3:0]          length_size, length_size_next;
  logic [3:0]          offset_size, offset_size_next;
  logic [3:0]          byte_index, byte_index_next;
  logic [LcnW-1:0]     field_acc, field_acc_next;
  logic [LcnW-1:0]     pending_length, pending_length_next;
  logic [LcnW-1:0]     absolute_offset, absolute_offset_next;
  logic [CountW-1:0]   clusters_done, clusters_done_next;
  logic [CountW-1:0]   clusters_left, clusters_left_next;
  logic [CountW-1:0]   cluster_total;

  // two-entry output buffer
  ndrd_pkg::result_t   head, tail;
  logic                head_valid, tail_valid;

  // working values
  ndrd_pkg::phase_t    ph_e;
  logic [3:0]          idx_e;
  logic [LcnW-1:0]     acc_e, pend_e, abs_e;
  logic [CountW-1:0]   done_e, left_e;
  logic [3:0]          size;
  logic [LcnW-1:0]     field;
  logic                last;
  logic [LcnW-1:0]     fin_len;
  logic [CountW-1:0]   count;
  logic [LcnW-1:0]     sum;
  logic                finish, sparse, run_end;
  logic                push;
  ndrd_pkg::result_t   res;

  logic                in_acc, out_acc, cfg_acc;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign cfg_ready = 1'b1;
  // a configuration request holds off run list bytes so none is lost
  assign in_stall = tail_valid || cfg_valid;

  always_comb begin
    // list_start restarts the list before the byte is decoded
    ph_e   = phase;
    idx_e  = byte_index;
    acc_e  = field_acc;
    pend_e = pending_length;
    abs_e  = absolute_offset;
    done_e = clusters_done;
    left_e = clusters_left;
    if (list_start) begin
      ph_e   = ndrd_pkg::PH_HEADER;
      idx_e  = '0;
      acc_e  = '0;
      pend_e = '0;
      abs_e  = '0;
      done_e = '0;
      left_e = cluster_total;
    end

    phase_next           = ph_e;
    length_size_next     = length_size;
    offset_size_next     = offset_size;
    byte_index_next      = idx_e;
    field_acc_next       = acc_e;
    pending_length_next  = pend_e;
    absolute_offset_next = abs_e;
    clusters_done_next   = done_e;
    clusters_left_next   = left_e;

    size = (ph_e == ndrd_pkg::PH_LENGTH) ? length_size : offset_size;

    // little-endian byte insert, bytes past the eighth are dropped
    field = acc_e;
    for (int k = 0; k < 8; k++) begin
      if (idx_e == 4'(k)) field[8*k +: 8] = field[8*k +: 8] | run_byte;
    end
    last = ({1'b0, idx_e} + 5'd1) >= {1'b0, size};
    // sign extension of a short field
    if (last && !size[3] && run_byte[7]) begin
      for (int k = 0; k < 8; k++) begin
        if (4'(k) >= size) field[8*k +: 8] = 8'hFF;
      end
    end

    fin_len = (ph_e == ndrd_pkg::PH_LENGTH) ? field : pend_e;
    count   = (fin_len > {{(LcnW-CountW){1'b0}}, left_e}) ? left_e : fin_len[CountW-1:0];
    sum     = abs_e + field;

    finish = 1'b0;
    sparse = 1'b0;
    push   = 1'b0;
    res    = '0;

    case (ph_e)
      ndrd_pkg::PH_HEADER: begin
        if (run_byte == 8'd0 || left_e == '0) begin
          phase_next   = ndrd_pkg::PH_ENDED;
          push         = 1'b1;
          res.list_end = 1'b1;
        end else begin
          length_size_next    = run_byte[3:0];
          offset_size_next    = run_byte[7:4];
          byte_index_next     = '0;
          field_acc_next      = '0;
          pending_length_next = '0;
          phase_next = (run_byte[3:0] != 4'd0) ? ndrd_pkg::PH_LENGTH : ndrd_pkg::PH_OFFSET;
        end
      end
      ndrd_pkg::PH_LENGTH: begin
        if (!last) begin
          field_acc_next  = field;
          byte_index_next = idx_e + 4'd1;
        end else begin
          byte_index_next     = '0;
          field_acc_next      = '0;
          pending_length_next = field;
          if (offset_size == 4'd0) begin
            finish = 1'b1;
            sparse = 1'b1;
          end else begin
            phase_next = ndrd_pkg::PH_OFFSET;
          end
        end
      end
      ndrd_pkg::PH_OFFSET: begin
        if (!last) begin
          field_acc_next  = field;
          byte_index_next = idx_e + 4'd1;
        end else begin
          byte_index_next = '0;
          finish          = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // count never exceeds what is left, so the run ends the list exactly when equal
    run_end = (count == left_e);
    if (finish) begin
      absolute_offset_next = sparse ? abs_e : sum;
      clusters_done_next   = done_e + count;
      clusters_left_next   = left_e - count;
      phase_next           = run_end ? ndrd_pkg::PH_ENDED : ndrd_pkg::PH_HEADER;
      field_acc_next       = '0;
      pending_length_next  = '0;
      push                 = 1'b1;
      res.run_valid         = 1'b1;
      res.run_clusters      = count;
      res.run_start_cluster = sparse ? '0 : sum;
      res.run_sparse        = sparse;
      res.list_end          = run_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ndrd_pkg::PH_HEADER;
      length_size     <= '0;
      offset_size     <= '0;
      byte_index      <= '0;
      field_acc       <= '0;
      pending_length  <= '0;
      absolute_offset <= '0;
      clusters_done   <= '0;
      clusters_left   <= '0;
      cluster_total   <= '0;
    end else if (cfg_acc) begin
      cluster_total <= cfg_total;
      clusters_left <= (cfg_total > clusters_done) ? cfg_total - clusters_done : '0;
    end else if (in_acc) begin
      phase           <= phase_next;
      length_size     <= length_size_next;
      offset_size     <= offset_size_next;
      byte_index      <= byte_index_next;
      field_acc       <= field_acc_next;
      pending_length  <= pending_length_next;
      absolute_offset <= absolute_offset_next;
      clusters_done   <= clusters_done_next;
      clusters_left   <= clusters_left_next;
    end
  end

  // output buffer: head drives the ports, tail catches a result while head is held
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      tail_valid <= 1'b0;
    end else if (out_acc || !head_valid) begin
      if (tail_valid) begin
        head_valid <= 1'b1;
        tail_valid <= 1'b0;
      end else begin
        head_valid <= in_acc && push;
      end
    end else if (in_acc && push) begin
      tail_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc || !head_valid) begin
      if (tail_valid) begin
        head <= tail;
      end else if (in_acc && push) begin
        head <= res;
      end
    end else if (in_acc && push) begin
      tail <= res;
    end
  end

  assign out_valid         = head_valid;
  assign run_valid         = head.run_valid;
  assign run_clusters      = head.run_clusters;
  assign run_start_cluster = head.run_start_cluster;
  assign run_sparse        = head.run_sparse;
  assign list_end          = head.list_end;

  // skid entry only fills behind a held head
  a_tail_behind_head: assert property (@(posedge clk) disable iff (rst)
    tail_valid |-> head_valid)
    else $error("skid entry full while head empty");

  // remaining count tracks total minus done, or zero once done reaches the total
  a_left_tracks_total: assert property (@(posedge clk) disable iff (rst)
    clusters_left == ((cluster_total > clusters_done) ? cluster_total - clusters_done : '0))
    else $error("remaining cluster count out of step");

  a_marker_is_end: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !head.run_valid) |-> (head.list_end && head.run_clusters == '0))
    else $error("bare marker without list end");

  a_sparse_no_start: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.run_sparse) |-> (head.run_start_cluster == '0))
    else $error("sparse run with a start cluster");

  // a result that marks the list end, from a finished run or a header, leaves the decoder ended
  a_end_stops: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !cfg_acc && push && res.list_end) |=> (phase == ndrd_pkg::PH_ENDED))
    else $error("list end without ended phase");

endmodule

FILE: bench/ntfs_data_run_decoder_test.sv
// self-checking bench for the data run decoder: predicted runs versus the block's output stream
`timescale 1ns / 100ps

module ntfs_data_run_decoder_test;

  localparam int CycleLimit = 600000;
  localparam logic [47:0] FullScale = 48'hFFFF_FFFF_FFFF;

  // tracks decode state and holds the runs still to come out
  class run_scoreboard;
    ndrd_pkg::result_t runs_due[$];
    ndrd_pkg::phase_t  phase;
    logic [3:0]        len_size;
    logic [3:0]        off_size;
    logic [3:0]        field_idx;
    logic [63:0]       field;
    logic [63:0]       run_len;
    logic [63:0]       lcn;
    logic [47:0]       done;
    logic [47:0]       total;
    int                errors;
    int                checked;

    function new();
      total   = '0;
      errors  = 0;
      checked = 0;
      clear_list();
    endfunction

    function void clear_list();
      phase     = ndrd_pkg::PH_HEADER;
      len_size  = '0;
      off_size  = '0;
      field_idx = '0;
      field     = '0;
      run_len   = '0;
      lcn       = '0;
      done      = '0;
    endfunction

    function void report(string what);
      errors++;
      $display("mismatch: %s", what);
    endfunction

    // little-endian collect, low 8 bytes kept, sign extension below 8 bytes
    function bit take_byte(logic [7:0] b, logic [3:0] size);
      if (field_idx < 4'd8) field |= {56'd0, b} << (8 * field_idx);
      if (int'(field_idx) + 1 >= int'(size)) begin
        if (size < 4'd8 && b[7]) field |= {64{1'b1}} << (8 * size);
        field_idx = '0;
        return 1'b1;
      end
      field_idx = field_idx + 4'd1;
      return 1'b0;
    endfunction

    function void close_run(bit sparse);
      logic [47:0]       left;
      logic [63:0]       count;
      ndrd_pkg::result_t r;
      left  = (total > done) ? total - done : '0;
      count = run_len;
      if (count > {16'd0, left}) count = {16'd0, left};
      r.run_start_cluster = '0;
      if (!sparse) begin
        lcn = lcn + field;
        r.run_start_cluster = lcn;
      end
      done           = done + count[47:0];
      r.run_valid    = 1'b1;
      r.run_clusters = count[47:0];
      r.run_sparse   = sparse;
      r.list_end     = (done >= total);
      phase   = r.list_end ? ndrd_pkg::PH_ENDED : ndrd_pkg::PH_HEADER;
      field   = '0;
      run_len = '0;
      runs_due = {runs_due, r};
    endfunction

    // returns 0 when the byte falls in the ended phase and is dropped
    function bit note_request(logic [7:0] b, logic start);
      ndrd_pkg::result_t r;
      if (start) clear_list();
      case (phase)
        ndrd_pkg::PH_HEADER: begin
          if (b == 8'h00 || done >= total) begin
            phase = ndrd_pkg::PH_ENDED;
            r = '0;
            r.list_end = 1'b1;
            runs_due = {runs_due, r};
          end else begin
            len_size  = b[3:0];
            off_size  = b[7:4];
            field_idx = '0;
            field     = '0;
            run_len   = '0;
            phase = (len_size != 4'd0) ? ndrd_pkg::PH_LENGTH : ndrd_pkg::PH_OFFSET;
          end
        end
        ndrd_pkg::PH_LENGTH: begin
          if (take_byte(b, len_size)) begin
            run_len = field;
            field   = '0;
            if (off_size == 4'd0) close_run(1'b1);
            else phase = ndrd_pkg::PH_OFFSET;
          end
        end
        ndrd_pkg::PH_OFFSET: begin
          if (take_byte(b, off_size)) close_run(1'b0);
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void check_result(ndrd_pkg::result_t got);
      ndrd_pkg::result_t want;
      checked++;
      if (runs_due.size() == 0) begin
        report($sformatf("unexpected result valid=%0b clusters=%0d start=%0h end=%0b",
                         got.run_valid, got.run_clusters, got.run_start_cluster, got.list_end));
        return;
      end
      want = runs_due.pop_front();
      if (got.run_valid !== want.run_valid)
        report($sformatf("result %0d run_valid %0b, want %0b", checked, got.run_valid,
                         want.run_valid));
      if (got.run_clusters !== want.run_clusters)
        report($sformatf("result %0d run_clusters %0d, want %0d", checked, got.run_clusters,
                         want.run_clusters));
      if (got.run_start_cluster !== want.run_start_cluster)
        report($sformatf("result %0d run_start_cluster %0h, want %0h", checked,
                         got.run_start_cluster, want.run_start_cluster));
      if (got.run_sparse !== want.run_sparse)
        report($sformatf("result %0d run_sparse %0b, want %0b", checked, got.run_sparse,
                         want.run_sparse));
      if (got.list_end !== want.list_end)
        report($sformatf("result %0d list_end %0b, want %0b", checked, got.list_end,
                         want.list_end));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  run_byte = 8'h00;
  logic        list_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        run_valid;
  logic [ndrd_pkg::CountW-1:0] run_clusters;
  logic [ndrd_pkg::LcnW-1:0]   run_start_cluster;
  logic        run_sparse;
  logic        list_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [ndrd_pkg::CountW-1:0] cfg_total = '0;

  run_scoreboard sb = new();
  int taken_requests = 0;
  int total_writes = 0;
  int burst_left = 0;
  int stall_left = 0;
  int cycles = 0;

  ntfs_data_run_decoder dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .run_byte          (run_byte),
    .list_start        (list_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .run_valid         (run_valid),
    .run_clusters      (run_clusters),
    .run_start_cluster (run_start_cluster),
    .run_sparse        (run_sparse),
    .list_end          (list_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_total         (cfg_total)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               sb.runs_due.size());
      $display("[ntfs_data_run_decoder] ERROR");
      $finish;
    end
  end

  // result side: sample, then pick the next stall
  always @(posedge clk) begin : take_results
    ndrd_pkg::result_t got;
    int r;
    if (!rst && out_valid && !out_stall) begin
      got.run_valid         = run_valid;
      got.run_clusters      = run_clusters;
      got.run_start_cluster = run_start_cluster;
      got.run_sparse        = run_sparse;
      got.list_end          = list_end;
      sb.check_result(got);
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        out_stall  <= 1'b0;
        stall_left <= $urandom_range(0, 20);
      end else if (r < 95) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  function automatic int next_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst_left = 30;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_request(logic [7:0] b, logic start);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    run_byte   <= b;
    list_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(sb.note_request(b, start));
    taken_requests++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.runs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_total(logic [47:0] v);
    cfg_valid <= 1'b1;
    cfg_total <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.total = v;
    total_writes++;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [3:0] pick_size(bit is_len);
    int r;
    r = $urandom_range(0, 99);
    if (is_len) begin
      if (r < 4) return 4'd0;
      if (r < 88) return 4'($urandom_range(1, 3));
      if (r < 97) return 4'($urandom_range(4, 8));
      return 4'($urandom_range(9, 15));
    end
    if (r < 15) return 4'd0;
    if (r < 85) return 4'($urandom_range(1, 4));
    if (r < 96) return 4'($urandom_range(5, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  task automatic send_run(logic start);
    logic [3:0] lsz;
    logic [3:0] osz;
    logic [7:0] b;
    lsz = pick_size(1'b1);
    osz = pick_size(1'b0);
    if ({osz, lsz} == 8'h00) lsz = 4'd1;
    send_request({osz, lsz}, start);
    // keep lengths mostly small so lists hold several runs
    for (int i = 0; i < int'(lsz); i++) begin
      b = (i == 0 || $urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
      if (i == int'(lsz) - 1 && $urandom_range(0, 9) != 0) b[7] = 1'b0;
      send_request(b, 1'b0);
    end
    for (int i = 0; i < int'(osz); i++) send_request(8'($urandom), 1'b0);
  endtask

  task automatic send_list(logic start);
    int runs;
    runs = $urandom_range(1, 6);
    for (int k = 0; k < runs; k++) send_run(k == 0 ? start : 1'b0);
    if ($urandom_range(0, 9) < 6) send_request(8'h00, 1'b0);
  endtask

  task automatic run_phase(int quota);
    int target;
    int r;
    target = taken_requests + quota;
    while (taken_requests < target) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        send_list(1'b1);
      end else if (r < 93) begin
        repeat ($urandom_range(1, 4)) send_request(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        // list cut short, the next list start interrupts it
        send_request(8'($urandom_range(1, 255)), 1'b1);
        repeat ($urandom_range(0, 3)) send_request(8'($urandom), 1'b0);
      end
    end
  endtask

  initial begin : stimulus
    int kind;
    logic [47:0] v;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // total still zero from reset, no list start: header ends at once, next byte dropped
    send_request(8'h11, 1'b0);
    send_request(8'h05, 1'b0);
    drain();
    write_total(48'd1000);
    send_request(8'h11, 1'b1);
    send_request(8'h10, 1'b0);
    send_request(8'h20, 1'b0);
    // negative offset
    send_request(8'h21, 1'b0);
    send_request(8'h05, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'hFF, 1'b0);
    // sparse run
    send_request(8'h01, 1'b0);
    send_request(8'h07, 1'b0);
    // no length field, offset with top bit set
    send_request(8'h10, 1'b0);
    send_request(8'h80, 1'b0);
    // nine byte offset, the top byte is dropped
    send_request(8'h90, 1'b0);
    for (int i = 1; i <= 8; i++) send_request(8'(i), 1'b0);
    send_request(8'hFF, 1'b0);
    // length sign extends to a huge count, clamped to what is left
    send_request(8'h01, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h11, 1'b0);
    send_request(8'h00, 1'b1);
    drain();

    for (int p = 0; p < 12; p++) begin
      kind = (p < 6) ? p : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 3);
      case (kind)
        0: v = '0;
        1: v = 48'd1;
        2: v = FullScale;
        3: v = 48'($urandom_range(1, 3000));
        4: v = (sb.done > 0) ? sb.done - 48'($urandom_range(0, 1)) : 48'd500;
        default: v = {16'($urandom), 32'($urandom)};
      endcase
      write_total(v);
      // half the time the open list carries on under the new total
      if (p > 0 && $urandom_range(0, 1) == 0) send_list(1'b0);
      run_phase(100);
      drain();
    end

    if (sb.runs_due.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.runs_due.size()));
    $display("covered %0d requests and %0d checked results over 13 totals",
             taken_requests, sb.checked);
    $display("totals written %0d times: zero, one, full scale, below progress, random",
             total_writes);
    if (sb.errors == 0) begin
      $display("[ntfs_data_run_decoder] OK");
    end else begin
      $display("[ntfs_data_run_decoder] ERROR");
    end
    $finish;
  end

endmodule
